// File: rtl/core/pwsmp_pkg.sv
// ----------------------------------------------------------------------------
// pwsmp_pkg
// shared widths, register indexes, reset values and structs of the pooling
// window sequencer
// ----------------------------------------------------------------------------
package pwsmp_pkg;

  localparam int ROW_W  = 10;  // unpooled row / column and bases
  localparam int CNT_W  = 8;   // group and output row / column counters
  localparam int OFF_W  = 2;   // offsets inside the window
  localparam int POOL_W = 3;   // pool_size register
  localparam int DIM_W  = 9;   // dimension registers
  localparam int IDX_W  = 2;   // configuration register index

  localparam int DEF_LANES      = 4;
  localparam int DEF_DATA_WIDTH = 16;

  // bits of the result word below the lane maxima
  localparam int META_W = 2 * ROW_W + 3 * CNT_W;

  localparam logic [IDX_W-1:0] REG_POOL_SIZE   = 2'd0;
  localparam logic [IDX_W-1:0] REG_OUT_HEIGHT  = 2'd1;
  localparam logic [IDX_W-1:0] REG_OUT_WIDTH   = 2'd2;
  localparam logic [IDX_W-1:0] REG_CHAN_GROUPS = 2'd3;

  localparam logic [POOL_W-1:0] RST_POOL_SIZE   = 3'd2;
  localparam logic [DIM_W-1:0]  RST_OUT_HEIGHT  = 9'd16;
  localparam logic [DIM_W-1:0]  RST_OUT_WIDTH   = 9'd16;
  localparam logic [DIM_W-1:0]  RST_CHAN_GROUPS = 9'd4;

  localparam logic [POOL_W-1:0] POOL_MAX = 3'd4;
  localparam logic [DIM_W-1:0]  DIM_MAX  = 9'd256;

  // effective limits after clamping, pool 1..4 and dimensions 1..256
  typedef struct packed {
    logic [POOL_W-1:0] pool;
    logic [DIM_W-1:0]  height;
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  groups;
  } limits_t;

  // position report of one request
  typedef struct packed {
    logic [ROW_W-1:0] in_row;
    logic [ROW_W-1:0] in_col;
    logic [CNT_W-1:0] chan_group;
    logic [CNT_W-1:0] out_row;
    logic [CNT_W-1:0] out_col;
    logic             window_start;
    logic             window_end;
  } pos_t;

endpackage

// File: rtl/core/pwsmp_config.sv
// ----------------------------------------------------------------------------
// pwsmp_config
// configuration registers with clamping of the window size and dimensions
// ----------------------------------------------------------------------------
module pwsmp_config (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       wr_en,
  input  logic [pwsmp_pkg::IDX_W-1:0] wr_index,
  input  logic [pwsmp_pkg::DIM_W-1:0] wr_data,
  output pwsmp_pkg::limits_t         limits
);
  import pwsmp_pkg::*;

  logic [POOL_W-1:0] pool_size;
  logic [DIM_W-1:0]  out_height;
  logic [DIM_W-1:0]  out_width;
  logic [DIM_W-1:0]  chan_groups;

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_size   <= RST_POOL_SIZE;
      out_height  <= RST_OUT_HEIGHT;
      out_width   <= RST_OUT_WIDTH;
      chan_groups <= RST_CHAN_GROUPS;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_POOL_SIZE:   pool_size   <= wr_data[POOL_W-1:0];
        REG_OUT_HEIGHT:  out_height  <= wr_data;
        REG_OUT_WIDTH:   out_width   <= wr_data;
        REG_CHAN_GROUPS: chan_groups <= wr_data;
      endcase
    end
  end

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    if (v == '0) return DIM_W'(1);
    else if (v > DIM_MAX) return DIM_MAX;
    else return v;
  endfunction

  always_comb begin
    if (pool_size == '0) limits.pool = POOL_W'(1);
    else if (pool_size > POOL_MAX) limits.pool = POOL_MAX;
    else limits.pool = pool_size;
    limits.height = clamp_dim(out_height);
    limits.width  = clamp_dim(out_width);
    limits.groups = clamp_dim(chan_groups);
  end

endmodule

// File: rtl/core/pwsmp_walk.sv
// ----------------------------------------------------------------------------
// pwsmp_walk
// nested window / group / column / row counters and the position they report
// ----------------------------------------------------------------------------
module pwsmp_walk (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,
  input  pwsmp_pkg::limits_t limits,
  output pwsmp_pkg::pos_t    pos
);
  import pwsmp_pkg::*;

  logic [ROW_W-1:0] row_base, col_base;
  logic [CNT_W-1:0] group_count, out_row_count, out_col_count;
  logic [OFF_W-1:0] row_offset, col_offset;

  logic col_wrap, row_wrap, group_wrap, ocol_wrap, orow_wrap;

  // a counter wraps once its next value reaches or passes the limit
  assign col_wrap   = (POOL_W'(col_offset) + POOL_W'(1)) >= limits.pool;
  assign row_wrap   = (POOL_W'(row_offset) + POOL_W'(1)) >= limits.pool;
  assign group_wrap = (DIM_W'(group_count) + DIM_W'(1)) >= limits.groups;
  assign ocol_wrap  = (DIM_W'(out_col_count) + DIM_W'(1)) >= limits.width;
  assign orow_wrap  = (DIM_W'(out_row_count) + DIM_W'(1)) >= limits.height;

  always_comb begin
    pos.in_row       = row_base + ROW_W'(row_offset);
    pos.in_col       = col_base + ROW_W'(col_offset);
    pos.chan_group   = group_count;
    pos.out_row      = out_row_count;
    pos.out_col      = out_col_count;
    pos.window_start = (row_offset == '0) && (col_offset == '0);
    pos.window_end   = col_wrap && row_wrap;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_base      <= '0;
      col_base      <= '0;
      group_count   <= '0;
      out_row_count <= '0;
      out_col_count <= '0;
      row_offset    <= '0;
      col_offset    <= '0;
    end else if (step) begin
      if (!col_wrap) begin
        col_offset <= col_offset + OFF_W'(1);
      end else begin
        col_offset <= '0;
        if (!row_wrap) begin
          row_offset <= row_offset + OFF_W'(1);
        end else begin
          row_offset <= '0;
          if (!group_wrap) begin
            group_count <= group_count + CNT_W'(1);
          end else begin
            group_count <= '0;
            if (!ocol_wrap) begin
              out_col_count <= out_col_count + CNT_W'(1);
              col_base      <= col_base + ROW_W'(limits.pool);
            end else begin
              out_col_count <= '0;
              col_base      <= '0;
              if (!orow_wrap) begin
                out_row_count <= out_row_count + CNT_W'(1);
                row_base      <= row_base + ROW_W'(limits.pool);
              end else begin
                out_row_count <= '0;
                row_base      <= '0;
              end
            end
          end
        end
      end
    end
  end

endmodule

// File: rtl/core/pwsmp_lane_max.sv
// ----------------------------------------------------------------------------
// pwsmp_lane_max
// per-lane running maximum, restarted on the first request of a window
// ----------------------------------------------------------------------------
module pwsmp_lane_max #(
  parameter int LANES      = pwsmp_pkg::DEF_LANES,
  parameter int DATA_WIDTH = pwsmp_pkg::DEF_DATA_WIDTH
) (
  input  logic                        clk,
  input  logic                        step,
  input  logic                        start,
  input  logic [LANES*DATA_WIDTH-1:0] lanes,
  output logic [LANES*DATA_WIDTH-1:0] maxima
);

  logic signed [DATA_WIDTH-1:0] cur [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    logic signed [DATA_WIDTH-1:0] v;
    assign v = lanes[i*DATA_WIDTH +: DATA_WIDTH];

    always_ff @(posedge clk) begin
      if (step && (start || (v > cur[i]))) begin
        cur[i] <= v;
      end
    end

    // the registers hold until the next request, so they double as output
    assign maxima[i*DATA_WIDTH +: DATA_WIDTH] = cur[i];
  end

endmodule

// File: rtl/core/pool_window_sequencer_max_pool_top.sv
// ----------------------------------------------------------------------------
// pool_window_sequencer_max_pool_top
// a result is registered and appears in the cycle after its request is accepted
// throughput: one request per cycle while results are taken, set by the single result register stage
// s_tready stays high while the result register is empty or being taken
// reset: synchronous; counters go to zero, registers to their defaults,
// the result register empties; lane maxima are rewritten on the first request
// ----------------------------------------------------------------------------
module pool_window_sequencer_max_pool_top #(
  parameter int LANES      = pwsmp_pkg::DEF_LANES,
  parameter int DATA_WIDTH = pwsmp_pkg::DEF_DATA_WIDTH
) (
  input  logic                        clk,
  input  logic                        rst,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // lane_0 .. lane_(LANES-1), zero padded to bytes
  input  logic [((LANES*DATA_WIDTH+7)/8)*8-1:0] s_tdata,
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // in_row, in_col, chan_group, out_row, out_col, max_0 .. max_(LANES-1),
  // zero padded to bytes
  output logic [((pwsmp_pkg::META_W+LANES*DATA_WIDTH+7)/8)*8-1:0] m_tdata,
  output logic                        m_tuser,  // window_start
  output logic                        m_tlast,  // window_end
  // configuration writes
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [pwsmp_pkg::IDX_W-1:0] cfg_index,
  input  logic [pwsmp_pkg::DIM_W-1:0] cfg_data
);
  import pwsmp_pkg::*;

  localparam int LANE_BITS  = LANES * DATA_WIDTH;
  localparam int OUT_TDATA_W = ((META_W + LANE_BITS + 7) / 8) * 8;

  limits_t limits;
  pos_t    pos, pos_q;
  logic    step;
  logic [LANE_BITS-1:0] maxima;

  assign cfg_ready = 1'b1;
  assign s_tready  = !m_tvalid || m_tready;
  assign step      = s_tvalid && s_tready;

  pwsmp_config u_config (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .limits   (limits)
  );

  pwsmp_walk u_walk (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .limits (limits),
    .pos    (pos)
  );

  pwsmp_lane_max #(
    .LANES      (LANES),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_lane_max (
    .clk    (clk),
    .step   (step),
    .start  (pos.window_start),
    .lanes  (s_tdata[LANE_BITS-1:0]),
    .maxima (maxima)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (step) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      pos_q <= pos;
    end
  end

  assign m_tdata = OUT_TDATA_W'({maxima, pos_q.out_col, pos_q.out_row,
                                 pos_q.chan_group, pos_q.in_col, pos_q.in_row});
  assign m_tuser = pos_q.window_start;
  assign m_tlast = pos_q.window_end;

endmodule

// File: rtl/core/pwsmp_checker.sv
// ----------------------------------------------------------------------------
// pwsmp_checker
// port-level checks of the pooling window sequencer, bound to the top level
// ----------------------------------------------------------------------------
module pwsmp_checker #(
  parameter int OUT_W = 112
) (
  input logic             clk,
  input logic             rst,
  input logic             s_tvalid,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata,
  input logic             m_tuser,
  input logic             m_tlast
);

  // result register is empty after reset
  assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // a stalled result holds
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                              && $stable(m_tlast))
    else $error("stalled result changed");

  // every accepted request shows up on the next cycle
  assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("accepted request produced no result");

  // an empty result slot never blocks the input
  assert property (@(posedge clk) disable iff (rst) !m_tvalid |-> s_tready)
    else $error("input stalled with empty result register");

  // the request after a window end opens a new window
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast && s_tvalid && s_tready |=> m_tuser)
    else $error("window end not followed by window start");

endmodule

bind pool_window_sequencer_max_pool_top pwsmp_checker #(
  .OUT_W (((pwsmp_pkg::META_W+LANES*DATA_WIDTH+7)/8)*8)
) u_pwsmp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// testbench for pool_window_sequencer_max_pool_top: lane vectors are streamed
// in under several window and layer shapes, each request is predicted by a
// scoreboard that walks the same nested counters and running lane maxima,
// and every result is compared field by field in arrival order
// ----------------------------------------------------------------------------
module tb;

  import pwsmp_pkg::*;

  localparam int LANES = DEF_LANES;
  localparam int DW    = DEF_DATA_WIDTH;
  localparam int SW    = ((LANES * DW + 7) / 8) * 8;
  localparam int MW    = ((META_W + LANES * DW + 7) / 8) * 8;
  localparam int LIMIT = 400000;

  typedef logic signed [DW-1:0] lanes_t [LANES];

  typedef struct {
    pos_t                 pos;
    logic signed [DW-1:0] lane_max [LANES];
  } window_result_t;

  // predicts the position report and running maxima of each request
  class pool_scoreboard;
    logic [POOL_W-1:0]    pool_reg;
    logic [DIM_W-1:0]     height_reg, width_reg, groups_reg;
    logic [ROW_W-1:0]     row_base, col_base;
    logic [CNT_W-1:0]     group_cnt, orow_cnt, ocol_cnt;
    logic [OFF_W-1:0]     row_off, col_off;
    logic signed [DW-1:0] run_max [LANES];
    window_result_t       expected_q [$];
    int                   n_errors;

    function new();
      pool_reg   = RST_POOL_SIZE;
      height_reg = RST_OUT_HEIGHT;
      width_reg  = RST_OUT_WIDTH;
      groups_reg = RST_CHAN_GROUPS;
      row_base   = '0;
      col_base   = '0;
      group_cnt  = '0;
      orow_cnt   = '0;
      ocol_cnt   = '0;
      row_off    = '0;
      col_off    = '0;
      foreach (run_max[i]) run_max[i] = '0;
      n_errors   = 0;
    endfunction

    function void write_reg(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
      case (idx)
        REG_POOL_SIZE:   pool_reg   = val[POOL_W-1:0];
        REG_OUT_HEIGHT:  height_reg = val;
        REG_OUT_WIDTH:   width_reg  = val;
        REG_CHAN_GROUPS: groups_reg = val;
        default: ;
      endcase
    endfunction

    // zero acts as one, anything above the ceiling as the ceiling
    function int unsigned clamp(int unsigned v, int unsigned hi);
      if (v == 0) return 1;
      return (v > hi) ? hi : v;
    endfunction

    function void note_request(lanes_t v);
      int unsigned    p, oh, ow, cg;
      bit             col_wrap, row_wrap, opens, closes;
      window_result_t r;
      p  = clamp(pool_reg, POOL_MAX);
      oh = clamp(height_reg, DIM_MAX);
      ow = clamp(width_reg, DIM_MAX);
      cg = clamp(groups_reg, DIM_MAX);
      col_wrap = (int'(col_off) + 1) >= p;
      row_wrap = (int'(row_off) + 1) >= p;
      opens    = (row_off == 0) && (col_off == 0);
      closes   = col_wrap && row_wrap;
      for (int i = 0; i < LANES; i++) begin
        if (opens || v[i] > run_max[i]) run_max[i] = v[i];
      end
      r.pos.in_row       = row_base + ROW_W'(row_off);
      r.pos.in_col       = col_base + ROW_W'(col_off);
      r.pos.chan_group   = group_cnt;
      r.pos.out_row      = orow_cnt;
      r.pos.out_col      = ocol_cnt;
      r.pos.window_start = opens;
      r.pos.window_end   = closes;
      r.lane_max         = run_max;
      expected_q.push_back(r);

      // counters step to zero once the next value reaches the limit
      if (!col_wrap) begin
        col_off = col_off + 1'b1;
      end else begin
        col_off = '0;
        if (!row_wrap) begin
          row_off = row_off + 1'b1;
        end else begin
          row_off = '0;
          if (int'(group_cnt) + 1 < cg) begin
            group_cnt = group_cnt + 1'b1;
          end else begin
            group_cnt = '0;
            if (int'(ocol_cnt) + 1 < ow) begin
              ocol_cnt = ocol_cnt + 1'b1;
              col_base = col_base + ROW_W'(p);
            end else begin
              ocol_cnt = '0;
              col_base = '0;
              if (int'(orow_cnt) + 1 < oh) begin
                orow_cnt = orow_cnt + 1'b1;
                row_base = row_base + ROW_W'(p);
              end else begin
                orow_cnt = '0;
                row_base = '0;
              end
            end
          end
        end
      end
    endfunction

    function void cmp(string field, logic signed [63:0] expd, logic signed [63:0] got);
      if (expd !== got) begin
        $error("%s: expected %0d, got %0d", field, expd, got);
        n_errors++;
      end
    endfunction

    function void check_result(logic [MW-1:0] d, logic ws, logic we);
      window_result_t e;
      if (expected_q.size() == 0) begin
        $error("result with no request outstanding: %h", d);
        n_errors++;
        return;
      end
      e = expected_q.pop_front();
      cmp("in_row", e.pos.in_row, d[0 +: ROW_W]);
      cmp("in_col", e.pos.in_col, d[ROW_W +: ROW_W]);
      cmp("chan_group", e.pos.chan_group, d[2*ROW_W +: CNT_W]);
      cmp("out_row", e.pos.out_row, d[2*ROW_W+CNT_W +: CNT_W]);
      cmp("out_col", e.pos.out_col, d[2*ROW_W+2*CNT_W +: CNT_W]);
      cmp("window_start", e.pos.window_start, ws);
      cmp("window_end", e.pos.window_end, we);
      for (int i = 0; i < LANES; i++) begin
        cmp($sformatf("max_%0d", i), e.lane_max[i], $signed(d[META_W+i*DW +: DW]));
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [SW-1:0]     s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [MW-1:0]     m_tdata;
  logic              m_tuser;
  logic              m_tlast;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [DIM_W-1:0]  cfg_data = '0;

  pool_scoreboard sb;
  bit             gaps_on;
  bit             stalls_on;
  bit             squeeze_req;
  int             hold_left;
  int             cycles;

  pool_window_sequencer_max_pool_top dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // result side back-pressure, with one long hold to fill the block
  always @(posedge clk) begin
    if (squeeze_req) begin
      squeeze_req = 1'b0;
      hold_left   = 120;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else if (stalls_on && $urandom_range(0, 4) == 0) begin
      hold_left = $urandom_range(1, 17) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
  end

  function automatic logic signed [DW-1:0] pick_lane();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(DW-1){1'b1}}};
      1: return {1'b1, {(DW-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return DW'($urandom);
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return DIM_W'(1);
      2: return DIM_MAX;
      3: return DIM_W'($urandom_range(257, 511));
      4: return DIM_W'($urandom_range(0, 511));
      default: return DIM_W'($urandom_range(2, 6));
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_pool();
    case ($urandom_range(0, 7))
      0: return DIM_W'($urandom_range(0, 511));
      1: return '0;
      2: return DIM_W'($urandom_range(5, 7));
      default: return DIM_W'($urandom_range(1, 4));
    endcase
  endfunction

  // leaves cfg_valid high; the caller lowers it after the last write
  task automatic cfg_write(logic [IDX_W-1:0] idx, logic [DIM_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic send_lanes(lanes_t v);
    logic [SW-1:0] word;
    word = '0;
    for (int i = 0; i < LANES; i++) word[i*DW +: DW] = v[i];
    s_tvalid <= 1'b1;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    sb.note_request(v);
  endtask

  task automatic send_random(int unsigned n);
    lanes_t v;
    for (int unsigned k = 0; k < n; k++) begin
      foreach (v[i]) v[i] = pick_lane();
      if (gaps_on && $urandom_range(0, 3) == 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk);
      end
      send_lanes(v);
    end
    s_tvalid <= 1'b0;
  endtask

  // block idle: every result back, plus a margin before returning
  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  initial begin
    lanes_t      v;
    int unsigned sent;
    int unsigned n;
    bit          long_done;
    sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset shape, 2x2 windows, lane extremes and mixed signs
    stalls_on = 1'b1;
    v = '{16'sh7fff, 16'sh8000, 16'sh0000, 16'shffff};
    send_lanes(v);
    v = '{16'sh8000, 16'sh7fff, 16'shffff, 16'sh0000};
    send_lanes(v);
    v = '{16'sh0001, 16'sh8001, 16'sh7ffe, 16'sh5555};
    send_lanes(v);
    v = '{16'shaaaa, 16'sh0000, 16'sh8000, 16'sh7fff};
    send_lanes(v);
    s_tvalid <= 1'b0;
    drain();

    // group counter now past a shrunk limit
    cfg_write(REG_POOL_SIZE, DIM_W'(1));
    cfg_write(REG_CHAN_GROUPS, DIM_W'(1));
    cfg_valid <= 1'b0;
    gaps_on = 1'b1;
    send_random(3);
    drain();

    // zero registers act as one
    cfg_write(REG_POOL_SIZE, '0);
    cfg_write(REG_OUT_HEIGHT, '0);
    cfg_write(REG_OUT_WIDTH, '0);
    cfg_write(REG_CHAN_GROUPS, '0);
    cfg_valid <= 1'b0;
    send_random(3);
    drain();

    // oversized registers clamp; stop partway through a 4x4 window
    cfg_write(REG_POOL_SIZE, DIM_W'(7));
    cfg_write(REG_OUT_HEIGHT, '1);
    cfg_write(REG_OUT_WIDTH, '1);
    cfg_write(REG_CHAN_GROUPS, '1);
    cfg_valid <= 1'b0;
    send_random(14);
    drain();

    // both offsets beyond a smaller window
    cfg_write(REG_POOL_SIZE, DIM_W'(2));
    cfg_valid <= 1'b0;
    send_random(2);
    drain();

    sent      = 0;
    long_done = 1'b0;
    while (sent < 750) begin
      if (!long_done && sent >= 250) begin
        // walk a full row of outputs while the result side holds off once
        cfg_write(REG_POOL_SIZE, DIM_W'(1));
        cfg_write(REG_CHAN_GROUPS, DIM_W'(1));
        cfg_write(REG_OUT_WIDTH, DIM_MAX);
        cfg_write(REG_OUT_HEIGHT, DIM_W'(3));
        cfg_valid <= 1'b0;
        gaps_on     = 1'b0;
        stalls_on   = 1'b1;
        squeeze_req = 1'b1;
        long_done   = 1'b1;
        n = 300;
      end else begin
        if ($urandom_range(0, 1)) cfg_write(REG_POOL_SIZE, pick_pool());
        if ($urandom_range(0, 1)) cfg_write(REG_OUT_HEIGHT, pick_dim());
        if ($urandom_range(0, 1)) cfg_write(REG_OUT_WIDTH, pick_dim());
        if ($urandom_range(0, 1)) cfg_write(REG_CHAN_GROUPS, pick_dim());
        cfg_valid <= 1'b0;
        gaps_on   = ($urandom_range(0, 9) < 7);
        stalls_on = ($urandom_range(0, 9) < 7);
        n = $urandom_range(8, 60);
      end
      if (sent >= 650) begin
        gaps_on   = 1'b0;
        stalls_on = 1'b0;
      end
      send_random(n);
      sent += n;
      drain();
    end

    repeat (4) @(posedge clk);
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/pwsmp_pkg.sv
rtl/core/pwsmp_config.sv
rtl/core/pwsmp_walk.sv
rtl/core/pwsmp_lane_max.sv
rtl/core/pool_window_sequencer_max_pool_top.sv
rtl/core/pwsmp_checker.sv
bench/tb.sv
